/* hw/rtl/m3i_pkg.sv */
// shared types, widths and helpers of the 3x3 matrix inverse
package m3i_pkg;

    localparam int ElemWidth = 32;
    localparam int FracBits  = 16;
    localparam int ProdWidth = 2 * ElemWidth;
    localparam int CofWidth  = ProdWidth + 1;
    localparam int DetWidth  = CofWidth + ElemWidth + 2;
    localparam int NumWidth  = CofWidth + 2 * FracBits;
    localparam int QuoWidth  = NumWidth;
    localparam int MagWidth  = NumWidth;
    localparam int DivWidth  = DetWidth;
    localparam int QueueDepth = 4;
    localparam int QueueAw    = $clog2(QueueDepth);
    localparam int InBytes    = (9 * ElemWidth + 7) / 8;
    localparam int OutBits    = 10 * ElemWidth + 1;
    localparam int OutBytes   = (OutBits + 7) / 8;

    typedef logic signed [ElemWidth-1:0] elem_t;
    typedef logic signed [ProdWidth-1:0] prod_t;
    typedef logic signed [CofWidth-1:0]  cof_t;
    typedef logic signed [DetWidth-1:0]  det_t;

    // front end to back end: adjugate, determinant and flag of one matrix
    typedef struct packed {
        cof_t [8:0] adj;
        det_t       det;
        logic       sing;
    } job_t;

    // saturate a wide signed value to the element format
    function automatic elem_t sat_elem(input logic signed [QuoWidth:0] v);
        logic signed [QuoWidth:0] hi;
        logic signed [QuoWidth:0] lo;
        hi = (QuoWidth+1)'({1'b0, {(ElemWidth-1){1'b1}}});
        lo = -hi - (QuoWidth+1)'(1);
        if (v > hi) begin
            return elem_t'({1'b0, {(ElemWidth-1){1'b1}}});
        end else if (v < lo) begin
            return elem_t'({1'b1, {(ElemWidth-1){1'b0}}});
        end
        return v[ElemWidth-1:0];
    endfunction

endpackage

/* hw/rtl/matrix3_inverse.sv */
// top level of the 3x3 matrix inverse by adjugate and determinant
//
//  channel | ports    | content
//  --------+----------+-----------------------------------------------
//  input   | s_axis_* | nine elements a_r1c1..a_r3c3, Q16.16
//  result  | m_axis_* | nine inverse elements, divisor_used, singular
//
// one matrix a cycle sustained while the result side is ready; from input to the earliest result
// transaction a matrix passes four front stages, one in the queue, a divider load stage,
// 97 quotient stages and the output register
// the divider lanes set the latency; the front multipliers set the clock
// reset clears all valid flags and the queue; payload is not reset
// a stalled result holds the divider pipe, the queue absorbs the front end
module matrix3_inverse (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // a_r1c1, a_r1c2, a_r1c3, a_r2c1, a_r2c2, a_r2c3, a_r3c1, a_r3c2, a_r3c3
    input  logic [8*m3i_pkg::InBytes-1:0]        s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // inv_r1c1 .. inv_r3c3, divisor_used, singular, zero fill
    output logic [8*m3i_pkg::OutBytes-1:0]       m_axis_tdata
);

    localparam int W = m3i_pkg::ElemWidth;

    m3i_pkg::elem_t [8:0] in_m;
    logic                 f_valid, f_ready, b_valid, b_ready;
    m3i_pkg::job_t        f_job, b_job;
    m3i_pkg::elem_t [9:0] q;
    logic                 sing;

    for (genvar i = 0; i < 9; i++) begin : g_unpack
        assign in_m[i] = s_axis_tdata[i*W +: W];
    end

    m3i_front u_front (
        .aclk, .aresetn,
        .in_valid (s_axis_tvalid), .in_m, .in_ready (s_axis_tready),
        .out_valid (f_valid), .out_job (f_job), .out_ready (f_ready)
    );

    m3i_queue u_queue (
        .aclk, .aresetn,
        .wr_valid (f_valid), .wr_job (f_job), .wr_ready (f_ready),
        .rd_valid (b_valid), .rd_job (b_job), .rd_ready (b_ready)
    );

    m3i_back u_back (
        .aclk, .aresetn,
        .in_valid (b_valid), .in_job (b_job), .in_ready (b_ready),
        .out_valid (m_axis_tvalid), .out_q (q), .out_sing (sing),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = (8*m3i_pkg::OutBytes)'({sing, q});

endmodule

/* hw/rtl/m3i_front.sv */
// front end: cofactor products, adjugate and determinant over four stages
module m3i_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  m3i_pkg::elem_t [8:0]   in_m,
    output logic                   in_ready,
    output logic                   out_valid,
    output m3i_pkg::job_t          out_job,
    input  logic                   out_ready
);

    // stage 1: the eighteen products
    logic                      v1_reg;
    m3i_pkg::prod_t [17:0]     p1_reg;
    m3i_pkg::elem_t [2:0]      r1_reg;
    // stage 2: cofactors
    logic                      v2_reg;
    m3i_pkg::cof_t  [8:0]      c2_reg;
    m3i_pkg::elem_t [2:0]      r2_reg;
    // stage 3: determinant terms split at the element width into high and low partials
    logic                      v3_reg;
    m3i_pkg::cof_t  [8:0]      c3_reg;
    m3i_pkg::cof_t  [2:0]      hp3_reg;
    m3i_pkg::cof_t  [2:0]      lp3_reg;
    // stage 4
    logic                      v4_reg;
    m3i_pkg::job_t             j4_reg;

    logic adv4, adv3, adv2, adv1;
    m3i_pkg::det_t det_sum;

    assign adv4 = !v4_reg || out_ready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign in_ready  = adv1;
    assign out_valid = v4_reg;
    assign out_job   = j4_reg;
    assign det_sum   = ((m3i_pkg::det_t'(hp3_reg[0]) + m3i_pkg::det_t'(hp3_reg[1])
                        + m3i_pkg::det_t'(hp3_reg[2])) <<< m3i_pkg::ElemWidth)
                     + m3i_pkg::det_t'(lp3_reg[0]) + m3i_pkg::det_t'(lp3_reg[1])
                     + m3i_pkg::det_t'(lp3_reg[2]);

    // product pairs for cof k: (x*y) - (u*v), negated on odd cofactors
    function automatic m3i_pkg::prod_t pm(input m3i_pkg::elem_t a, input m3i_pkg::elem_t b);
        return m3i_pkg::prod_t'(a) * m3i_pkg::prod_t'(b);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
        if (adv1) begin
            p1_reg[0]  <= pm(in_m[4], in_m[8]); p1_reg[1]  <= pm(in_m[5], in_m[7]);
            p1_reg[2]  <= pm(in_m[1], in_m[8]); p1_reg[3]  <= pm(in_m[2], in_m[7]);
            p1_reg[4]  <= pm(in_m[1], in_m[5]); p1_reg[5]  <= pm(in_m[2], in_m[4]);
            p1_reg[6]  <= pm(in_m[3], in_m[8]); p1_reg[7]  <= pm(in_m[5], in_m[6]);
            p1_reg[8]  <= pm(in_m[0], in_m[8]); p1_reg[9]  <= pm(in_m[2], in_m[6]);
            p1_reg[10] <= pm(in_m[0], in_m[5]); p1_reg[11] <= pm(in_m[2], in_m[3]);
            p1_reg[12] <= pm(in_m[3], in_m[7]); p1_reg[13] <= pm(in_m[4], in_m[6]);
            p1_reg[14] <= pm(in_m[0], in_m[7]); p1_reg[15] <= pm(in_m[1], in_m[6]);
            p1_reg[16] <= pm(in_m[0], in_m[4]); p1_reg[17] <= pm(in_m[1], in_m[3]);
            r1_reg <= {in_m[2], in_m[1], in_m[0]};
        end
        if (adv2) begin
            for (int k = 0; k < 9; k++) begin
                if (k[0]) begin
                    c2_reg[k] <= m3i_pkg::cof_t'(p1_reg[2*k+1]) - m3i_pkg::cof_t'(p1_reg[2*k]);
                end else begin
                    c2_reg[k] <= m3i_pkg::cof_t'(p1_reg[2*k]) - m3i_pkg::cof_t'(p1_reg[2*k+1]);
                end
            end
            r2_reg <= r1_reg;
        end
        if (adv3) begin
            c3_reg <= c2_reg;
            // row one element times the signed high and unsigned low half of its cofactor
            for (int j = 0; j < 3; j++) begin
                hp3_reg[j] <= m3i_pkg::cof_t'(r2_reg[j]) * m3i_pkg::cof_t'(
                    $signed(c2_reg[3*j][m3i_pkg::CofWidth-1:m3i_pkg::ElemWidth]));
                lp3_reg[j] <= m3i_pkg::cof_t'(r2_reg[j])
                    * m3i_pkg::cof_t'(c2_reg[3*j][m3i_pkg::ElemWidth-1:0]);
            end
        end
        if (adv4) begin
            j4_reg.adj  <= c3_reg;
            j4_reg.sing <= (det_sum == '0);
            j4_reg.det  <= (det_sum == '0) ?
                m3i_pkg::det_t'(1) <<< (3 * m3i_pkg::FracBits) : det_sum;
        end
    end

endmodule

/* hw/rtl/m3i_queue.sv */
// short fifo that decouples the front end from the divider back end
module m3i_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    input  m3i_pkg::job_t  wr_job,
    output logic           wr_ready,
    output logic           rd_valid,
    output m3i_pkg::job_t  rd_job,
    input  logic           rd_ready
);

    m3i_pkg::job_t                 mem_reg [m3i_pkg::QueueDepth];
    logic [m3i_pkg::QueueAw-1:0]   wp_reg, rp_reg;
    logic [m3i_pkg::QueueAw:0]     cnt_reg;
    logic                          push, pop;

    assign wr_ready = (cnt_reg != (m3i_pkg::QueueAw+1)'(m3i_pkg::QueueDepth));
    assign rd_valid = (cnt_reg != '0);
    assign rd_job   = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (m3i_pkg::QueueAw+1)'(push) - (m3i_pkg::QueueAw+1)'(pop);
        end
        if (push) mem_reg[wp_reg] <= wr_job;
    end

endmodule

/* hw/rtl/m3i_back.sv */
// back end: nine pipelined restoring dividers, one quotient bit per stage
module m3i_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  m3i_pkg::job_t          in_job,
    output logic                   in_ready,
    output logic                   out_valid,
    output m3i_pkg::elem_t [9:0]   out_q,
    output logic                   out_sing,
    input  logic                   out_ready
);

    localparam int N  = m3i_pkg::QuoWidth;
    localparam int DW = m3i_pkg::DivWidth;

    // per stage: remainder, dividend shift, quotient per lane; shared divisor
    logic                 v_reg   [N+1];
    logic [DW:0]          rem_reg [N+1][9];
    logic [N-1:0]         num_reg [N+1][9];
    logic                 neg_reg [N+1][9];
    logic [DW-1:0]        dv_reg  [N+1];
    logic                 dn_reg  [N+1];
    logic                 sg_reg  [N+1];
    logic                 adv     [N+1];
    logic                 ov_reg;
    m3i_pkg::elem_t [9:0] oq_reg;
    logic                 os_reg;
    logic                 oadv;

    logic [DW-1:0]        dmag;
    logic                 dneg;

    assign dneg = in_job.det[DW-1];
    assign dmag = dneg ? DW'(-in_job.det) : DW'(in_job.det);

    assign oadv = !ov_reg || out_ready;
    assign adv[N] = !v_reg[N] || oadv;
    for (genvar s = N - 1; s >= 0; s--) begin : g_adv
        assign adv[s] = !v_reg[s] || adv[s+1];
    end
    assign in_ready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= N; s++) v_reg[s] <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            if (adv[0]) v_reg[0] <= in_valid;
            for (int s = 1; s <= N; s++) if (adv[s]) v_reg[s] <= v_reg[s-1];
            if (oadv) ov_reg <= v_reg[N];
        end
        // load: magnitudes of scaled cofactors, divisor magnitude and sign
        if (adv[0]) begin
            dv_reg[0] <= dmag;
            dn_reg[0] <= dneg;
            sg_reg[0] <= in_job.sing;
            for (int k = 0; k < 9; k++) begin
                logic signed [N-1:0] nv;
                nv = N'(in_job.adj[k]) <<< (2 * m3i_pkg::FracBits);
                num_reg[0][k] <= nv[N-1] ? N'(-nv) : N'(nv);
                neg_reg[0][k] <= nv[N-1] ^ dneg;
                rem_reg[0][k] <= '0;
            end
        end
        for (int s = 1; s <= N; s++) begin
            if (adv[s]) begin
                dv_reg[s] <= dv_reg[s-1];
                dn_reg[s] <= dn_reg[s-1];
                sg_reg[s] <= sg_reg[s-1];
                for (int k = 0; k < 9; k++) begin
                    logic [DW:0] r;
                    logic [DW:0] d;
                    r = {rem_reg[s-1][k][DW-1:0], num_reg[s-1][k][N-1]};
                    d = {1'b0, dv_reg[s-1]};
                    neg_reg[s][k] <= neg_reg[s-1][k];
                    if (r >= d) begin
                        rem_reg[s][k] <= r - d;
                        num_reg[s][k] <= {num_reg[s-1][k][N-2:0], 1'b1};
                    end else begin
                        rem_reg[s][k] <= r;
                        num_reg[s][k] <= {num_reg[s-1][k][N-2:0], 1'b0};
                    end
                end
            end
        end
        if (oadv) begin
            logic signed [N:0] dq;
            os_reg <= sg_reg[N];
            for (int k = 0; k < 9; k++) begin
                logic signed [N:0] qv;
                qv = {1'b0, num_reg[N][k]};
                if (neg_reg[N][k]) qv = -qv;
                oq_reg[k] <= m3i_pkg::sat_elem(qv);
            end
            // divisor_used: det magnitude shifted down by 2F, sign put back
            dq = (N+1)'(dv_reg[N] >> (2 * m3i_pkg::FracBits));
            if (dn_reg[N]) dq = -dq;
            oq_reg[9] <= m3i_pkg::sat_elem(dq);
        end
    end

    assign out_valid = ov_reg;
    assign out_q     = oq_reg;
    assign out_sing  = os_reg;

endmodule

/* verif/tb_matrix3_inverse.sv */
// self-checking testbench of the 3x3 matrix inverse with a fixed-point adjugate predictor
`timescale 1ns / 100ps

module tb_matrix3_inverse;

    localparam int ElemWidth = m3i_pkg::ElemWidth;
    localparam int FracBits  = m3i_pkg::FracBits;
    localparam int InBytes   = m3i_pkg::InBytes;
    localparam int OutBits   = m3i_pkg::OutBits;
    localparam int OutBytes  = m3i_pkg::OutBytes;

    localparam int WideW    = 256;
    localparam int LimitCyc = 400000;
    localparam int NumRand  = 1930;
    localparam int Drain    = 300;

    typedef m3i_pkg::elem_t elem_t;
    typedef logic signed [WideW-1:0] wide_t;
    typedef elem_t mat_t [9];

    // inverse element, divisor and flag of one matrix
    class inverse_scoreboard;
        logic [OutBits-1:0] pending_inv [$];
        int errors;
        int matched;
        int singulars;
        int saturated;

        function automatic elem_t clip(wide_t v);
            wide_t hi;
            wide_t lo;
            hi = (wide_t'(1) <<< (ElemWidth - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) begin
                return {1'b0, {(ElemWidth-1){1'b1}}};
            end else if (v < lo) begin
                return {1'b1, {(ElemWidth-1){1'b0}}};
            end
            return v[ElemWidth-1:0];
        endfunction

        function automatic logic [OutBits-1:0] invert(mat_t a);
            wide_t m [9];
            wide_t adj [9];
            wide_t det;
            wide_t q;
            logic [OutBits-1:0] r;
            for (int i = 0; i < 9; i++) m[i] = a[i];
            adj[0] = m[4] * m[8] - m[5] * m[7];
            adj[1] = m[2] * m[7] - m[1] * m[8];
            adj[2] = m[1] * m[5] - m[2] * m[4];
            adj[3] = m[5] * m[6] - m[3] * m[8];
            adj[4] = m[0] * m[8] - m[2] * m[6];
            adj[5] = m[2] * m[3] - m[0] * m[5];
            adj[6] = m[3] * m[7] - m[4] * m[6];
            adj[7] = m[1] * m[6] - m[0] * m[7];
            adj[8] = m[0] * m[4] - m[1] * m[3];
            det = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
            r = '0;
            // singular matrix: divide by exactly one
            if (det == 0) begin
                r[OutBits-1] = 1'b1;
                det = wide_t'(1) <<< (3 * FracBits);
            end
            for (int i = 0; i < 9; i++) begin
                q = (adj[i] <<< (2 * FracBits)) / det;
                r[ElemWidth*i +: ElemWidth] = clip(q);
            end
            r[ElemWidth*9 +: ElemWidth] = clip(det / (wide_t'(1) <<< (2 * FracBits)));
            return r;
        endfunction

        function void note_matrix(mat_t a);
            pending_inv.push_back(invert(a));
        endfunction

        task report(string what, logic [ElemWidth-1:0] got, logic [ElemWidth-1:0] want);
            errors++;
            $display("mismatch on result %0d, %s: got %h expected %h", matched, what, got, want);
        endtask

        task check_result(logic [8*OutBytes-1:0] data);
            logic [OutBits-1:0] want;
            if (pending_inv.size() == 0) begin
                report("unexpected transaction", data[31:0], 'x);
                return;
            end
            want = pending_inv.pop_front();
            for (int i = 0; i < 9; i++) begin
                if (data[ElemWidth*i +: ElemWidth] !== want[ElemWidth*i +: ElemWidth])
                    report($sformatf("inv_r%0dc%0d", i / 3 + 1, i % 3 + 1),
                           data[ElemWidth*i +: ElemWidth], want[ElemWidth*i +: ElemWidth]);
                if (want[ElemWidth*i +: ElemWidth] == {1'b0, {(ElemWidth-1){1'b1}}} ||
                    want[ElemWidth*i +: ElemWidth] == {1'b1, {(ElemWidth-1){1'b0}}})
                    saturated++;
            end
            if (data[ElemWidth*9 +: ElemWidth] !== want[ElemWidth*9 +: ElemWidth])
                report("divisor_used", data[ElemWidth*9 +: ElemWidth],
                       want[ElemWidth*9 +: ElemWidth]);
            if (data[OutBits-1] !== want[OutBits-1])
                report("singular", data[OutBits-1], want[OutBits-1]);
            if (want[OutBits-1]) singulars++;
            matched++;
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [8*InBytes-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [8*OutBytes-1:0] m_axis_tdata;

    inverse_scoreboard sb = new();
    int cycles = 0;
    bit quiet = 1'b0;      // no idling on either side while set
    bit hold_req = 1'b0;   // receiver holds off for a long stretch

    matrix3_inverse dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LimitCyc) begin
            $display("timeout with %0d results outstanding", sb.pending_inv.size());
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // receiver: random back-pressure per transaction, plus one long hold-off
    initial begin
        int w;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                hold_req = 1'b0;
            end
            w = quiet ? 0 : $urandom_range(0, 14);
            if (w > 0) begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    task automatic send_matrix(mat_t a);
        int gap;
        logic [8*InBytes-1:0] d;
        d = '0;
        for (int i = 0; i < 9; i++) d[ElemWidth*i +: ElemWidth] = a[i];
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_matrix(a);
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic elem_t rnd_elem(int kind);
        case (kind)
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
            2: return $signed($urandom_range(0, 32'h0000_0400)) - 32'sh0000_0200;
            default: return $urandom_range(0, 1) ? {1'b0, {31{1'b1}}} : {1'b1, {31{1'b0}}};
        endcase
    endfunction

    initial begin
        mat_t a;
        int kind;
        elem_t mx;
        elem_t mn;
        mx = {1'b0, {31{1'b1}}};
        mn = {1'b1, {31{1'b0}}};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero, identity, extremes, singular and near-singular cases
        quiet = 1'b1;
        foreach (a[i]) a[i] = 0;
        send_matrix(a);
        foreach (a[i]) a[i] = (i % 4 == 0) ? 32'sh0001_0000 : 0;
        send_matrix(a);
        foreach (a[i]) a[i] = mx;
        send_matrix(a);
        foreach (a[i]) a[i] = mn;
        send_matrix(a);
        foreach (a[i]) a[i] = (i % 4 == 0) ? mx : 0;
        send_matrix(a);
        foreach (a[i]) a[i] = (i % 4 == 0) ? mn : 0;
        send_matrix(a);
        foreach (a[i]) a[i] = (i % 4 == 0) ? 32'sh0000_0001 : 0;
        send_matrix(a);
        foreach (a[i]) a[i] = (i % 4 == 0) ? -32'sh0000_0001 : 0;
        send_matrix(a);
        foreach (a[i]) a[i] = (i % 2) ? mn : mx;
        send_matrix(a);
        foreach (a[i]) a[i] = i + 1;                  // rank two, singular
        send_matrix(a);
        foreach (a[i]) a[i] = (i % 3 == 0) ? mx : 0;  // one nonzero column
        send_matrix(a);
        foreach (a[i]) a[i] = 32'sh0001_0000 * (i + 1);
        a[8] = 32'sh000A_0000;
        send_matrix(a);
        foreach (a[i]) a[i] = (i == 2 || i == 4 || i == 6) ? 32'sh0002_0000 : 0;
        send_matrix(a);
        foreach (a[i]) a[i] = $urandom();
        a[3] = a[0]; a[4] = a[1]; a[5] = a[2];
        send_matrix(a);
        foreach (a[i]) a[i] = 32'h5555_5555;
        send_matrix(a);
        foreach (a[i]) a[i] = 32'hAAAA_AAAA;
        send_matrix(a);
        quiet = 1'b0;

        for (int n = 0; n < NumRand; n++) begin
            if (n % 200 == 0) quiet = ($urandom_range(0, 3) == 0);
            if (n == 600) hold_req = 1'b1;
            if (n == 1200) begin
                // sender pauses until every result is back
                s_axis_tvalid <= 1'b0;
                wait (sb.pending_inv.size() == 0);
            end
            kind = $urandom_range(0, 9);
            for (int i = 0; i < 9; i++)
                a[i] = rnd_elem(kind < 4 ? 0 : kind < 7 ? 1 : kind < 9 ? 2 : $urandom_range(0, 3));
            // sometimes make a row or column dependent to hit the singular path
            if ($urandom_range(0, 9) == 0) begin
                a[6] = a[0]; a[7] = a[1]; a[8] = a[2];
            end else if ($urandom_range(0, 19) == 0) begin
                a[2] = a[1]; a[5] = a[4]; a[8] = a[7];
            end
            send_matrix(a);
        end
        s_axis_tvalid <= 1'b0;

        wait (sb.pending_inv.size() == 0);
        repeat (Drain) @(posedge aclk);
        $display("checked %0d inverses, %0d singular, %0d saturated elements",
                 sb.matched, sb.singulars, sb.saturated);
        $display("directed extremes, random wide and small matrices, back-pressure and hold-off");
        if (sb.errors == 0 && sb.pending_inv.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
